// ===== hw/rtl/sstc_pkg.sv =====
`default_nettype none

package sstc_pkg;

  localparam int SUM_W         = 26;
  localparam int VAL_W         = 16;
  localparam int CNT_W         = 20;
  localparam int OCC_W         = 11;
  localparam int MAX_ITEMS_DEF = 1024;

  // configuration port
  localparam int PDATA_W = 32;
  localparam int ADDR_W  = 3;
  localparam logic [ADDR_W-3:0] REG_TARGET_SUM = 1'b0;

  // one request travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             skip;     // beyond the length limit: no lookup, no record
    logic             over;     // array was truncated
    logic [SUM_W-1:0] prefix;
    logic [SUM_W-1:0] want;
    logic             matched;
    logic             placed;
    logic [OCC_W-1:0] count;
  } token_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sstc_front.sv =====
`default_nettype none

module sstc_front import sstc_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic             last,
  input  wire logic [SUM_W-1:0] target,
  output token_t                tk_out
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [SUM_W-1:0] prefix_total;
  logic [CW-1:0]    items_seen;
  logic             overflowed;

  logic             accept;
  logic             over_item;
  logic [SUM_W-1:0] prefix_next;
  token_t           tk_next;

  assign accept      = in_valid && adv;
  assign over_item   = (items_seen == CW'(MAX_ITEMS));
  assign prefix_next = prefix_total + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};

  always_comb begin
    tk_next         = '0;
    tk_next.valid   = accept && (!over_item || last);
    tk_next.last    = last;
    tk_next.skip    = over_item;
    tk_next.over    = overflowed || over_item;
    tk_next.prefix  = prefix_next;
    tk_next.want    = prefix_next - target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_total <= '0;
      items_seen   <= '0;
      overflowed   <= 1'b0;
      tk_out       <= '0;
    end else if (adv) begin
      tk_out <= tk_next;
      if (accept) begin
        if (last) begin
          prefix_total <= '0;
          items_seen   <= '0;
          overflowed   <= 1'b0;
        end else if (over_item) begin
          overflowed <= 1'b1;
        end else begin
          prefix_total <= prefix_next;
          items_seen   <= items_seen + CW'(1);
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    items_seen <= CW'(MAX_ITEMS))
    else $error("item count past limit");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (prefix_total == '0 && items_seen == '0 && !overflowed))
    else $error("array state not cleared after last request");

endmodule

`default_nettype wire

// ===== hw/rtl/sstc_cell.sv =====
`default_nettype none

module sstc_cell import sstc_pkg::*; #(
  parameter bit HOME = 1'b0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  token_t    tin,
  output token_t    tout
);

  logic             vld;
  logic [SUM_W-1:0] key;
  logic [OCC_W-1:0] occ;

  logic             vld_next;
  logic [SUM_W-1:0] key_next;
  logic [OCC_W-1:0] occ_next;
  token_t           tout_next;

  always_comb begin
    tout_next = tin;
    vld_next  = vld;
    key_next  = key;
    occ_next  = occ;
    if (tin.valid && !tin.skip) begin
      // lookup sees the table before this request's own record
      if (vld && key == tin.want && !tin.matched) begin
        tout_next.matched = 1'b1;
        tout_next.count   = occ;
      end
      if (!tin.placed) begin
        if (vld && key == tin.prefix) begin
          tout_next.placed = 1'b1;
          if (occ != '1) begin
            occ_next = occ + OCC_W'(1);
          end
        end else if (!vld) begin
          // first free cell takes the new prefix
          tout_next.placed = 1'b1;
          vld_next         = 1'b1;
          key_next         = tin.prefix;
          occ_next         = OCC_W'(1);
        end
      end
    end
    if (tin.valid && tin.last) begin
      vld_next = HOME;
      key_next = '0;
      occ_next = OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= HOME;
      key  <= '0;
      occ  <= OCC_W'(1);
      tout <= '0;
    end else if (adv) begin
      vld  <= vld_next;
      key  <= key_next;
      occ  <= occ_next;
      tout <= tout_next;
    end
  end

  a_home_valid: assert property (@(posedge clk) disable iff (rst)
    HOME |-> vld)
    else $error("home cell lost prefix zero");

  a_key_held: assert property (@(posedge clk) disable iff (rst)
    (vld && !(adv && tin.valid && tin.last)) |=> (vld && $stable(key)))
    else $error("occupied cell changed key without a clear");

endmodule

`default_nettype wire

// ===== hw/rtl/sstc_tail.sv =====
`default_nettype none

module sstc_tail import sstc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  token_t                tk,
  input  wire logic             out_ready,
  output logic                  adv,
  output logic                  out_valid,
  output logic [CNT_W-1:0]      match_count,
  output logic                  too_long
);

  logic [CNT_W-1:0] acc;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sat;

  assign sum = {1'b0, acc} + (CNT_W+1)'(tk.count);
  assign sat = sum[CNT_W] ? '1 : sum[CNT_W-1:0];

  // chain holds only while a finished result is still waiting behind another
  assign adv = !(tk.valid && tk.last && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      out_valid   <= 1'b0;
      match_count <= '0;
      too_long    <= 1'b0;
    end else begin
      if (adv && tk.valid && tk.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv && tk.valid) begin
        if (tk.last) begin
          match_count <= sat;
          too_long    <= tk.over;
          acc         <= '0;
        end else begin
          acc <= sat;
        end
      end
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && tk.valid && tk.last) |=> out_valid)
    else $error("last request left no result");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && tk.valid && tk.last) |=> (acc == '0))
    else $error("match total not cleared at end of array");

endmodule

`default_nettype wire

// ===== hw/rtl/subarray_sum_target_counter_top.sv =====
// Subarray sum target counter.
// Input channel (in_valid/in_ready): one signed value per request, last marks
// the final element of an array. Output channel (out_valid/out_ready): one
// result per array, the number of contiguous subarrays summing to target_sum
// and a flag set when the array ran past MAX_ITEMS elements (extra elements
// are dropped, a last flag on them still closes the array).
// target_sum is written over the APB-style port at byte address 0.
// Each request walks a row of MAX_ITEMS+1 cells, one cell per cycle while the
// row is not held; every cell holds one distinct prefix sum and its occurrence
// count. One request is taken every cycle while the row is not held; the
// result of an array passes through the front register, every cell of the
// row and the output register once its last request is taken. A last request
// clears each cell as it passes, so the next array can follow directly behind it.
// Reset empties the row, leaving prefix zero once, and clears target_sum.
// When the receiver stalls, the output register holds the result and requests
// keep flowing until another finished result reaches the end of the row; then
// the whole row and in_ready hold until the output is taken.
`default_nettype none

module subarray_sum_target_counter_top import sstc_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VAL_W-1:0]   value,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [CNT_W-1:0]   match_count,
  output logic                    too_long
);

  localparam int CELLS = MAX_ITEMS + 1;

  logic [SUM_W-1:0] target_sum;
  logic             adv;
  logic             sel_target;
  token_t           link [CELLS+1];

  assign pready     = 1'b1;
  assign sel_target = (paddr[ADDR_W-1:2] == REG_TARGET_SUM);
  assign prdata     = sel_target ? {{(PDATA_W-SUM_W){target_sum[SUM_W-1]}}, target_sum} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && pready && sel_target) begin
      target_sum <= pwdata[SUM_W-1:0];
    end
  end

  assign in_ready = adv;

  sstc_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .value    (value),
    .last     (last),
    .target   (target_sum),
    .tk_out   (link[0])
  );

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    sstc_cell #(
      .HOME (g == 0)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .tin  (link[g]),
      .tout (link[g+1])
    );
  end

  sstc_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .tk          (link[CELLS]),
    .out_ready   (out_ready),
    .adv         (adv),
    .out_valid   (out_valid),
    .match_count (match_count),
    .too_long    (too_long)
  );

endmodule

`default_nettype wire
